// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on the rising edge
`define AST_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, clocked on the rising edge
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== src/wpdm_pkg.sv =====
// Shared constants, types and elaboration-time helpers of the peak level meter
package wpdm_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS   = 12;
  localparam int COUNT_BITS    = 16;
  localparam int WLEN_BITS     = 16;
  localparam int OFFSET_BITS   = 14;
  localparam int LEVEL_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Register map
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SENS_OFFSET   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_NOISE_THRESH  = CFG_IDX_BITS'(2);

  // Register reset values (42 dB offset, 50 dB threshold)
  localparam logic [WLEN_BITS-1:0]          WLEN_RESET   = WLEN_BITS'(4000);
  localparam logic [OFFSET_BITS-1:0]        OFFSET_RESET = OFFSET_BITS'(10752);
  localparam logic signed [LEVEL_BITS-1:0]  THRESH_RESET = LEVEL_BITS'(12800);

  // Log2 datapath: Q1.30 mantissa, Q.24 result, one fraction bit per stage
  localparam int FRAC_BITS  = 24;
  localparam int EXP_BITS   = $clog2(SAMPLE_BITS);
  localparam int MANT_BITS  = 31;
  localparam int SQ_BITS    = 2 * MANT_BITS;
  localparam int LOG_STAGES = FRAC_BITS;
  localparam int SHIFT_BITS = $clog2(MANT_BITS);

  // dB scaling: s is signed Q.24, product is Q.40
  localparam int S_BITS      = EXP_BITS + FRAC_BITS + 2;
  localparam int K_BITS      = 28;
  localparam int P_BITS      = S_BITS + K_BITS;
  localparam int ROUND_SHIFT = 40;
  localparam int TERM_BITS   = LEVEL_BITS + 2;
  localparam int SUM_BITS    = TERM_BITS + 1;

  localparam int FS_INT    = (1 << SAMPLE_BITS) - 1;
  // Smallest peak at or above 10 mV: 330 * peak >= full scale
  localparam int LOW_LIMIT = (FS_INT + 329) / 330;
  localparam int LOG2_VREF = 28898185;   // log2(3.3) in Q.24

  localparam logic signed [K_BITS-1:0] K_DB = K_BITS'(101008905); // 5120*log10(2), Q.16
  localparam logic [P_BITS-1:0] ROUND_HALF = P_BITS'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [SUM_BITS-1:0] LEVEL_MAX = SUM_BITS'((1 << (LEVEL_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] LEVEL_MIN = -SUM_BITS'(1 << (LEVEL_BITS - 1));

  // Bit-exact log2 in Q.24 by repeated squaring, evaluated at elaboration only
  function automatic logic [31:0] log2_q24_const(input logic [31:0] v);
    logic [63:0] m;
    logic [31:0] acc;
    int          e;
    e = 0;
    for (int k = 0; k < 32; k++) begin
      if (v[k]) e = k;
    end
    m   = 64'(v) << (30 - e);
    acc = 32'(e) << FRAC_BITS;
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m   = m >> 1;
        acc = acc | (32'd1 << i);
      end
    end
    return acc;
  endfunction

  // log2(3.3) - log2(full scale), Q.24
  localparam int LOG2_OFFSET = LOG2_VREF - int'(log2_q24_const(32'(FS_INT)));
  localparam logic signed [S_BITS-1:0] S_OFFSET = S_BITS'(LOG2_OFFSET);

  // Log2 result of one finished window
  typedef struct packed {
    logic                   low;
    logic [EXP_BITS-1:0]    expo;
    logic [FRAC_BITS-1:0]   frac;
    logic [SAMPLE_BITS-1:0] peak;
  } log_res_t;

  // Registers seen by the level stage
  typedef struct packed {
    logic [OFFSET_BITS-1:0]        offset;
    logic signed [LEVEL_BITS-1:0]  threshold;
  } level_cfg_t;

endpackage

// ===== src/wpdm_window.sv =====
// Window accumulator: running peak and sample count, emits the peak at window end
module wpdm_window import wpdm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [WLEN_BITS-1:0]   window_length,
  output logic                   pk_valid,
  input  logic                   pk_ready,
  output logic [SAMPLE_BITS-1:0] pk_peak
);

  localparam int CMP_BITS = (COUNT_BITS + 1 > WLEN_BITS) ? COUNT_BITS + 1 : WLEN_BITS;

  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic                   pv_r, pv_nxt;
  logic [SAMPLE_BITS-1:0] pk_r, pk_nxt;
  logic [SAMPLE_BITS-1:0] peak_max;
  logic [WLEN_BITS-1:0]   len;
  logic [CMP_BITS-1:0]    cnt_inc;
  logic                   win_end;
  logic                   accept;

  // Hand-off register may take a new window peak when empty or draining
  assign in_ready = !pv_r || pk_ready;
  assign accept   = in_valid && in_ready;

  // Running max, length zero treated as one, end test on the widened count
  assign peak_max = (in_sample > peak_r) ? in_sample : peak_r;
  assign len      = (window_length == '0) ? WLEN_BITS'(1) : window_length;
  assign cnt_inc  = CMP_BITS'(count_r) + CMP_BITS'(1);
  assign win_end  = cnt_inc >= CMP_BITS'(len);

  // Next state
  always_comb begin
    count_nxt = count_r;
    peak_nxt  = peak_r;
    pv_nxt    = pv_r && !pk_ready;
    pk_nxt    = pk_r;
    if (accept) begin
      if (win_end) begin
        count_nxt = '0;
        peak_nxt  = '0;
        pv_nxt    = 1'b1;
        pk_nxt    = peak_max;
      end else begin
        count_nxt = cnt_inc[COUNT_BITS-1:0];
        peak_nxt  = peak_max;
      end
    end
  end

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      peak_r  <= '0;
      pv_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      peak_r  <= peak_nxt;
      pv_r    <= pv_nxt;
    end
  end

  // Peak payload
  always_ff @(posedge clk) begin
    pk_r <= pk_nxt;
  end

  assign pk_valid = pv_r;
  assign pk_peak  = pk_r;

endmodule

// ===== src/wpdm_log2_pipe.sv =====
// Pipelined log2 of the window peak: normalise, then one squaring per stage
module wpdm_log2_pipe import wpdm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [SAMPLE_BITS-1:0] up_peak,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output log_res_t               dn_res
);

  localparam int NST = LOG_STAGES + 1;

  logic [NST-1:0]       v_r;
  logic [NST:0]         ld;
  log_res_t             res_r   [NST];
  log_res_t             res_nxt [NST];
  logic [MANT_BITS-1:0] mant_r   [LOG_STAGES];
  logic [MANT_BITS-1:0] mant_nxt [LOG_STAGES];
  logic [EXP_BITS-1:0]  e0;

  // Stall chain: a stage loads when empty or when the one after it loads
  assign ld[NST] = dn_ready;
  for (genvar k = 0; k < NST; k++) begin : g_ld
    assign ld[k] = !v_r[k] || ld[k+1];
  end
  assign up_ready = ld[0];

  // Stage 0: top set bit and Q1.30 mantissa
  always_comb begin
    e0 = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (up_peak[i]) e0 = EXP_BITS'(i);
    end
  end

  assign mant_nxt[0] = MANT_BITS'(up_peak) << (SHIFT_BITS'(MANT_BITS - 1) - SHIFT_BITS'(e0));
  assign res_nxt[0]  = '{low:  (up_peak < SAMPLE_BITS'(LOW_LIMIT)),
                         expo: e0,
                         frac: '0,
                         peak: up_peak};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ld[0]) begin
      v_r[0] <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      res_r[0]  <= res_nxt[0];
      mant_r[0] <= mant_nxt[0];
    end
  end

  // Stages 1..LOG_STAGES: square, truncate to Q1.30, halve and record a bit at >= 2.0
  for (genvar k = 1; k < NST; k++) begin : g_sq
    logic [SQ_BITS-1:0]   sq;
    logic [MANT_BITS:0]   sh;

    assign sq = SQ_BITS'(mant_r[k-1]) * SQ_BITS'(mant_r[k-1]);
    assign sh = sq[SQ_BITS-1 -: MANT_BITS+1];

    assign res_nxt[k] = '{low:  res_r[k-1].low,
                          expo: res_r[k-1].expo,
                          frac: res_r[k-1].frac | (FRAC_BITS'(sh[MANT_BITS]) << (FRAC_BITS - k)),
                          peak: res_r[k-1].peak};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        res_r[k] <= res_nxt[k];
      end
    end

    // The last stage needs no mantissa
    if (k < LOG_STAGES) begin : g_mant
      assign mant_nxt[k] = sh[MANT_BITS] ? sh[MANT_BITS:1] : sh[MANT_BITS-1:0];

      always_ff @(posedge clk) begin
        if (ld[k]) begin
          mant_r[k] <= mant_nxt[k];
        end
      end
    end
  end

  assign dn_valid = v_r[NST-1];
  assign dn_res   = res_r[NST-1];

endmodule

// ===== src/wpdm_level.sv =====
// Level stage: dB scaling, rounding, offset, saturation and noise flag
module wpdm_level import wpdm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  log_res_t                      up_res,
  input  level_cfg_t                    cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [LEVEL_BITS-1:0]  out_level_db,
  output logic [SAMPLE_BITS-1:0]        out_peak_count,
  output logic                          out_high_noise
);

  logic                          ld_a, ld_b, ld_c;
  logic                          a_v_r, b_v_r, out_valid_r;
  logic signed [S_BITS-1:0]      s_r, s_nxt;
  logic                          a_low_r, b_low_r;
  logic [SAMPLE_BITS-1:0]        a_peak_r, b_peak_r, peak_out_r;
  logic signed [P_BITS-1:0]      p_r, p_nxt;
  logic                          neg;
  logic [P_BITS-1:0]             mag, rnd;
  logic signed [TERM_BITS-1:0]   tmag, term;
  logic signed [SUM_BITS-1:0]    sum, sat;
  logic signed [LEVEL_BITS-1:0]  level_nxt, level_r;
  logic                          noise_nxt, noise_r;

  // Stall chain
  assign ld_c     = !out_valid_r || out_ready;
  assign ld_b     = !b_v_r || ld_c;
  assign ld_a     = !a_v_r || ld_b;
  assign up_ready = ld_a;

  // Stage A: log2(peak) + log2(3.3) - log2(full scale)
  assign s_nxt = $signed(S_BITS'({up_res.expo, up_res.frac})) + S_OFFSET;

  // Stage B: scale to 1/256 dB in Q.40
  assign p_nxt = P_BITS'(s_r) * P_BITS'(K_DB);

  // Stage C: round half away from zero, add offset, clamp, flag
  always_comb begin
    neg  = p_r[P_BITS-1];
    mag  = neg ? P_BITS'(-p_r) : P_BITS'(p_r);
    rnd  = (mag + ROUND_HALF) >> ROUND_SHIFT;
    tmag = $signed(TERM_BITS'(rnd));
    term = b_low_r ? '0 : (neg ? -tmag : tmag);
    sum  = $signed(SUM_BITS'(cfg.offset)) + SUM_BITS'(term);
    priority if (sum > LEVEL_MAX) begin
      sat = LEVEL_MAX;
    end else if (sum < LEVEL_MIN) begin
      sat = LEVEL_MIN;
    end else begin
      sat = sum;
    end
    level_nxt = LEVEL_BITS'(sat);
    noise_nxt = level_nxt > cfg.threshold;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld_a) a_v_r <= up_valid;
      if (ld_b) b_v_r <= a_v_r;
      if (ld_c) out_valid_r <= b_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ld_a) begin
      s_r      <= s_nxt;
      a_low_r  <= up_res.low;
      a_peak_r <= up_res.peak;
    end
    if (ld_b) begin
      p_r      <= p_nxt;
      b_low_r  <= a_low_r;
      b_peak_r <= a_peak_r;
    end
    if (ld_c) begin
      level_r    <= level_nxt;
      noise_r    <= noise_nxt;
      peak_out_r <= b_peak_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_level_db   = level_r;
  assign out_peak_count = peak_out_r;
  assign out_high_noise = noise_r;

endmodule

// ===== src/window_peak_decibel_meter.sv =====
// Top level of the window peak level meter in 1/256 dB
//
// Input channel (in_valid/in_ready/in_sample): one 12-bit converter sample per
// request. The block keeps the running peak and a sample count; only the last
// sample of a window produces a result request on the output channel
// (out_level_db, out_peak_count, out_high_noise). Other samples give nothing.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// window length, sensitivity offset and noise threshold; it is always ready.
// The user must write it only while the block is idle; nothing enforces it.
// A result passes the window register, the normalise stage, 24 squaring
// stages and the level stages (log offset, scale, round and clamp).
// Throughput: one sample per cycle while in_ready is high; the log2 pipeline
// yields one fraction bit per stage, so even windows of length one run at
// full rate. Reset clears the count, the peak and every pipeline valid bit,
// and loads the register defaults (4000 samples, 42 dB, 50 dB).
// When the receiver stalls, the result holds in the output register; the
// pipeline stages fill up behind it and in_ready drops only once the window
// register can no longer drain.
module window_peak_decibel_meter import wpdm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [LEVEL_BITS-1:0]  out_level_db,
  output logic [SAMPLE_BITS-1:0]        out_peak_count,
  output logic                          out_high_noise,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  logic [WLEN_BITS-1:0]          wlen_r;
  logic [OFFSET_BITS-1:0]        offset_r;
  logic signed [LEVEL_BITS-1:0]  thresh_r;
  logic                          pk_valid, pk_ready;
  logic [SAMPLE_BITS-1:0]        pk_peak;
  logic                          lg_valid, lg_ready;
  log_res_t                      lg_res;
  level_cfg_t                    lvl_cfg;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r   <= WLEN_RESET;
      offset_r <= OFFSET_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: wlen_r   <= cfg_data[WLEN_BITS-1:0];
        REG_SENS_OFFSET:   offset_r <= cfg_data[OFFSET_BITS-1:0];
        REG_NOISE_THRESH:  thresh_r <= $signed(cfg_data[LEVEL_BITS-1:0]);
        default: ;
      endcase
    end
  end

  assign lvl_cfg = '{offset: offset_r, threshold: thresh_r};

  // Window accumulator
  wpdm_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .window_length (wlen_r),
    .pk_valid      (pk_valid),
    .pk_ready      (pk_ready),
    .pk_peak       (pk_peak)
  );

  // Log2 pipeline
  wpdm_log2_pipe u_log2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pk_valid),
    .up_ready (pk_ready),
    .up_peak  (pk_peak),
    .dn_valid (lg_valid),
    .dn_ready (lg_ready),
    .dn_res   (lg_res)
  );

  // Level, clamp and flag
  wpdm_level u_level (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (lg_valid),
    .up_ready       (lg_ready),
    .up_res         (lg_res),
    .cfg            (lvl_cfg),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level_db   (out_level_db),
    .out_peak_count (out_peak_count),
    .out_high_noise (out_high_noise)
  );

endmodule

// ===== src/wpdm_checker.sv =====
// Port-level checks of the peak level meter, bound to the top level
`include "assert_macros.svh"

module wpdm_checker import wpdm_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [LEVEL_BITS-1:0]  out_level_db,
  input logic [SAMPLE_BITS-1:0]        out_peak_count,
  input logic                          out_high_noise
);

  // Reset empties the output register
  `AST_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid)

  // Without back-pressure from the receiver the input side never stalls
  `AST_SAME(a_ready_free, clk, !rst_n, !out_valid || out_ready, in_ready)

  // A stalled result stays offered
  `AST_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid)

  // A stalled result keeps its payload
  `AST_NEXT(a_out_stable, clk, !rst_n, out_valid && !out_ready, $stable(out_level_db) && $stable(out_peak_count) && $stable(out_high_noise))

endmodule

bind window_peak_decibel_meter wpdm_checker u_wpdm_checker (.*);
